// File: hw/rtl/bba_pkg.sv
// Package for the block bitmap allocator: sizes, codes, payload and control types.
package bba_pkg;

   localparam int MAX_BLOCKS = 65536;
   localparam int WORD_BITS = 32;
   localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = $clog2(NWORDS);
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int BLK_W = 16;
   localparam int CNT_W = 17;

   localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(65536);

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_RANGE   = 2'd2,
      STAT_UNUSED  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_TOTAL    = 1'b0,
      CSR_RESERVED = 1'b1
   } csr_idx_type;

   typedef struct packed {
      cmd_type          command;
      logic [BLK_W-1:0] block_number;
   } req_data_type;

   typedef struct packed {
      logic [BLK_W-1:0] result_block;
      logic             bit_value;
      logic [CNT_W-1:0] free_count;
      status_type       status;
   } rsp_data_type;

   typedef struct packed {
      logic capture;
      logic sweep;
      logic init_end;
      logic scan;
      logic acc_chk;
   } ctrl_cmd_type;

   typedef struct packed {
      logic free_zero;
      logic range_err;
      logic sweep_last;
      logic scan_hit;
      logic scan_miss;
   } dp_status_type;

   // Position of the first clear bit, counted from the most significant bit.
   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] k;
      k = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!w[i]) begin
            k = BIT_W'(WORD_BITS - 1 - i);
         end
      end
      return k;
   endfunction

   function automatic logic [WORD_BITS-1:0] bit_mask(input logic [BIT_W-1:0] k);
      return {1'b1, {(WORD_BITS-1){1'b0}}} >> k;
   endfunction

   // Map word after init for word address addr with r leading blocks reserved.
   function automatic logic [WORD_BITS-1:0] init_word(input logic [ADDR_W-1:0] addr,
                                                      input logic [CNT_W-1:0] r);
      logic [CNT_W-1:0]     base;
      logic [CNT_W-1:0]     n;
      logic [WORD_BITS-1:0] w;
      base = CNT_W'({addr, {BIT_W{1'b0}}});
      n = '0;
      if (r >= base + CNT_W'(WORD_BITS)) begin
         w = '1;
      end else if (r <= base) begin
         w = '0;
      end else begin
         n = r - base;
         w = ~({WORD_BITS{1'b1}} >> n[BIT_W-1:0]);
      end
      return w;
   endfunction

endpackage

// File: hw/rtl/bba_ctrl.sv
// Controller state machine of the block bitmap allocator.
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bba_pkg::cmd_type       req_cmd,
   input  bba_pkg::dp_status_type dp_stat,
   output bba_pkg::ctrl_cmd_type  dp_cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_INIT   = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_ACC_RD = 7'b0010000,
      ST_ACC_CK = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  bba_pkg::CMD_INIT: state_in = ST_INIT;
                  bba_pkg::CMD_ALLOC: begin
                     state_in = dp_stat.free_zero ? ST_DONE : ST_SCAN;
                  end
                  bba_pkg::CMD_FREE, bba_pkg::CMD_READ: begin
                     state_in = dp_stat.range_err ? ST_DONE : ST_ACC_RD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_INIT: begin
            if (dp_stat.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (dp_stat.scan_hit || dp_stat.scan_miss) begin
               state_in = ST_DONE;
            end
         end
         ST_ACC_RD: state_in = ST_ACC_CK;
         ST_ACC_CK: state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      dp_cmd.capture  = (state_ff == ST_IDLE) && start;
      dp_cmd.sweep    = (state_ff == ST_CLEAR) || (state_ff == ST_INIT);
      dp_cmd.init_end = (state_ff == ST_INIT) && dp_stat.sweep_last;
      dp_cmd.scan     = (state_ff == ST_SCAN);
      dp_cmd.acc_chk  = (state_ff == ST_ACC_CK);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// File: hw/rtl/bba_dpath.sv
// Datapath of the block bitmap allocator: map memory, counters and result registers.
module bba_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bba_pkg::req_data_type               req_data,
   input  logic                                csr_we,
   input  bba_pkg::csr_idx_type                csr_index,
   input  logic [bba_pkg::CNT_W-1:0]           csr_data,
   input  bba_pkg::ctrl_cmd_type               dp_cmd,
   output bba_pkg::dp_status_type              dp_stat,
   output bba_pkg::rsp_data_type               rsp_data
);

   logic [bba_pkg::WORD_BITS-1:0] map_mem [bba_pkg::NWORDS];

   logic [bba_pkg::CNT_W-1:0]     total_ff, total_in;
   logic [bba_pkg::CNT_W-1:0]     reserved_ff, reserved_in;
   logic [bba_pkg::CNT_W-1:0]     free_ff, free_in;
   logic [bba_pkg::CNT_W-1:0]     r_ff, r_in;
   logic [bba_pkg::ADDR_W:0]      addr_ff, addr_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          primed_ff, primed_in;
   logic [bba_pkg::ADDR_W-1:0]    chk_ff, chk_in;
   bba_pkg::cmd_type              cmd_ff, cmd_in;
   logic [bba_pkg::BLK_W-1:0]     bn_ff, bn_in;
   bba_pkg::rsp_data_type         rsp_ff, rsp_in;
   logic [bba_pkg::WORD_BITS-1:0] rd_ff;

   logic [bba_pkg::CNT_W-1:0]     eff_total;
   logic [bba_pkg::CNT_W-1:0]     r_now;
   logic [bba_pkg::CNT_W:0]       nw_sum;
   logic [bba_pkg::ADDR_W:0]      nw;
   logic [bba_pkg::BIT_W-1:0]     fz;
   logic [bba_pkg::BLK_W-1:0]     hit_block;
   logic                          has_zero;
   logic                          hit;
   logic                          miss;
   logic                          acc_bit;
   logic [bba_pkg::ADDR_W-1:0]    bn_word;
   logic                          mem_we;
   logic [bba_pkg::ADDR_W-1:0]    mem_waddr;
   logic [bba_pkg::ADDR_W-1:0]    mem_raddr;
   logic [bba_pkg::WORD_BITS-1:0] mem_wdata;
   logic                          req_range;

   assign eff_total = (total_ff > bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)) ?
                      bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) : total_ff;
   assign r_now     = (reserved_ff > eff_total) ? eff_total : reserved_ff;
   assign nw_sum    = {1'b0, eff_total} + (bba_pkg::CNT_W + 1)'(bba_pkg::WORD_BITS - 1);
   assign nw        = nw_sum[bba_pkg::BIT_W +: (bba_pkg::ADDR_W + 1)];

   assign fz        = bba_pkg::first_zero(rd_ff);
   assign has_zero  = ~&rd_ff;
   assign hit_block = {chk_ff, fz};
   assign hit       = primed_ff && rd_valid_ff && has_zero &&
                      (bba_pkg::CNT_W'(hit_block) < eff_total);
   assign miss      = primed_ff && !hit && (!rd_valid_ff || has_zero);

   assign bn_word   = bn_ff[bba_pkg::BIT_W +: bba_pkg::ADDR_W];
   assign acc_bit   = |(rd_ff & bba_pkg::bit_mask(bn_ff[bba_pkg::BIT_W-1:0]));
   assign req_range = bba_pkg::CNT_W'(req_data.block_number) >= eff_total;

   always_comb begin
      dp_stat.free_zero  = (free_ff == '0);
      dp_stat.range_err  = req_range;
      dp_stat.sweep_last = (addr_ff == (bba_pkg::ADDR_W + 1)'(bba_pkg::NWORDS - 1));
      dp_stat.scan_hit   = hit;
      dp_stat.scan_miss  = miss;
   end

   always_comb begin
      mem_raddr = dp_cmd.scan ? addr_ff[bba_pkg::ADDR_W-1:0] : bn_word;
      mem_we    = 1'b0;
      mem_waddr = bn_word;
      mem_wdata = rd_ff & ~bba_pkg::bit_mask(bn_ff[bba_pkg::BIT_W-1:0]);
      priority if (dp_cmd.sweep) begin
         mem_we    = 1'b1;
         mem_waddr = addr_ff[bba_pkg::ADDR_W-1:0];
         mem_wdata = bba_pkg::init_word(addr_ff[bba_pkg::ADDR_W-1:0], r_ff);
      end else if (dp_cmd.scan) begin
         mem_we    = hit;
         mem_waddr = chk_ff;
         mem_wdata = rd_ff | bba_pkg::bit_mask(fz);
      end else if (dp_cmd.acc_chk) begin
         mem_we    = (cmd_ff == bba_pkg::CMD_FREE) && acc_bit;
      end else begin
         mem_we    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[mem_raddr];
   end

   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      free_in     = free_ff;
      r_in        = r_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_valid_ff;
      primed_in   = primed_ff;
      chk_in      = chk_ff;
      cmd_in      = cmd_ff;
      bn_in       = bn_ff;
      rsp_in      = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            bba_pkg::CSR_TOTAL:    total_in = csr_data;
            bba_pkg::CSR_RESERVED: reserved_in = csr_data;
            default:               total_in = total_ff;
         endcase
      end

      if (dp_cmd.capture) begin
         cmd_in      = req_data.command;
         bn_in       = req_data.block_number;
         r_in        = r_now;
         addr_in     = '0;
         rd_valid_in = 1'b0;
         primed_in   = 1'b0;
         rsp_in.bit_value = 1'b0;
         rsp_in.status    = bba_pkg::STAT_OK;
         if ((req_data.command == bba_pkg::CMD_FREE) ||
             (req_data.command == bba_pkg::CMD_READ)) begin
            rsp_in.result_block = req_data.block_number;
            if (req_range) begin
               rsp_in.status = bba_pkg::STAT_RANGE;
            end
         end else begin
            rsp_in.result_block = '0;
            if ((req_data.command == bba_pkg::CMD_ALLOC) && (free_ff == '0)) begin
               rsp_in.status = bba_pkg::STAT_NOSPACE;
            end
         end
      end

      if (dp_cmd.sweep) begin
         addr_in = addr_ff + 1'b1;
      end

      if (dp_cmd.init_end) begin
         free_in = eff_total - r_ff;
      end

      if (dp_cmd.scan) begin
         addr_in     = addr_ff + 1'b1;
         rd_valid_in = (addr_ff < nw);
         chk_in      = addr_ff[bba_pkg::ADDR_W-1:0];
         primed_in   = 1'b1;
         if (hit) begin
            free_in = free_ff - 1'b1;
            rsp_in.result_block = hit_block;
         end
         if (miss) begin
            rsp_in.status = bba_pkg::STAT_NOSPACE;
         end
      end

      if (dp_cmd.acc_chk) begin
         if (cmd_ff == bba_pkg::CMD_READ) begin
            rsp_in.bit_value = acc_bit;
         end else if (acc_bit && (free_ff != '1)) begin
            free_in = free_ff + 1'b1;
         end
      end

      rsp_in.free_count = free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= bba_pkg::TOTAL_RESET;
         reserved_ff <= '0;
         free_ff     <= '0;
         r_ff        <= '0;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         primed_ff   <= 1'b0;
      end else begin
         total_ff    <= total_in;
         reserved_ff <= reserved_in;
         free_ff     <= free_in;
         r_ff        <= r_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= rd_valid_in;
         primed_ff   <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
      cmd_ff <= cmd_in;
      bn_ff  <= bn_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hw/rtl/block_bitmap_allocator_top.sv
// Top level of the block bitmap allocator: first-fit allocator over an occupancy bitmap.
//
// A command is transferred at a rising edge with start high and busy low; its
// fields are command and block_number in req_data. Each command gives exactly
// one result on rsp_data, shown for one cycle with rsp_valid high. The receiver
// cannot stall; the result must be taken in that cycle.
// Configuration registers (index 0 total blocks, index 1 reserved blocks) are
// written over the csr channel, which is always ready; write them only while idle.
// Free and read pass through a map read state and a check state before the result;
// an out-of-range free or read and an allocate with no free block go straight to
// the result, init rewrites every one of the 2048 map words, and allocate scans
// at most the total rounded up to whole 32-bit words; the scan reads one map word
// per cycle over a single read port. Busy falls in the cycle after the result, so
// the next command can be accepted there.
// After reset the block clears every map word in one pass with busy high;
// the free count is zero until the first init.
module block_bitmap_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  bba_pkg::req_data_type       req_data,
   output logic                        rsp_valid,
   output bba_pkg::rsp_data_type       rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  bba_pkg::csr_idx_type        csr_index,
   input  logic [bba_pkg::CNT_W-1:0]   csr_data
);

   bba_pkg::ctrl_cmd_type dp_cmd;
   bba_pkg::dp_status_type dp_stat;

   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_data.command),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bba_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_data  (rsp_data)
   );

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after a command transfer");

   a_nospace_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bba_pkg::STAT_NOSPACE)) |->
      (rsp_data.result_block == '0))
      else $error("failed allocate returned a nonzero block");

   a_sweep_exclusive: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.sweep |-> !(dp_cmd.scan || dp_cmd.acc_chk || dp_cmd.capture))
      else $error("map sweep overlaps another datapath operation");

endmodule

// File: sim/block_bitmap_allocator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the block bitmap allocator: directed table, then random phases.
module block_bitmap_allocator_top_tb;
   import bba_pkg::*;

   typedef enum logic {
      ROW_CMD = 1'b0,
      ROW_REG = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_idx_type   idx;
      logic [16:0]   val;
      req_data_type  req;
      bit            typed;
      rsp_data_type  want;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_data_type  req_data = '0;
   logic          rsp_valid;
   rsp_data_type  rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_idx_type   csr_index = CSR_TOTAL;
   logic [16:0]   csr_data = '0;

   logic [65535:0] occ_map = '0;
   logic [16:0]    free_cnt = '0;
   logic [16:0]    reg_total = TOTAL_RESET;
   logic [16:0]    reg_reserved = '0;

   rsp_data_type   pending_rsp[$];
   logic [15:0]    held_blocks[$];
   stim_row_type   plan[$];
   int             fails = 0;
   int             cmd_seen[4] = '{0, 0, 0, 0};
   int             stat_seen[4] = '{0, 0, 0, 0};
   int             reg_writes = 0;
   rsp_data_type   want_rsp;

   block_bitmap_allocator_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [16:0] tracked_blocks();
      return (reg_total > 17'd65536) ? 17'd65536 : reg_total;
   endfunction

   function automatic rsp_data_type apply_command(req_data_type rq);
      rsp_data_type rs;
      logic [16:0]  lim;
      logic [16:0]  r;
      bit           hit;
      lim = tracked_blocks();
      rs = '0;
      rs.status = STAT_OK;
      hit = 0;
      case (rq.command)
         CMD_INIT: begin
            r = (reg_reserved > lim) ? lim : reg_reserved;
            occ_map = '0;
            for (int b = 0; b < r; b++) occ_map[b] = 1'b1;
            free_cnt = lim - r;
         end
         CMD_ALLOC: begin
            if (free_cnt != 0) begin
               for (int b = 0; b < lim && !hit; b++) begin
                  if (!occ_map[b]) begin
                     occ_map[b] = 1'b1;
                     free_cnt = free_cnt - 1'b1;
                     rs.result_block = b[15:0];
                     hit = 1;
                  end
               end
            end
            if (!hit) rs.status = STAT_NOSPACE;
         end
         CMD_FREE: begin
            rs.result_block = rq.block_number;
            if ({1'b0, rq.block_number} >= lim) begin
               rs.status = STAT_RANGE;
            end else if (occ_map[rq.block_number]) begin
               occ_map[rq.block_number] = 1'b0;
               if (free_cnt != 17'h1FFFF) free_cnt = free_cnt + 1'b1;
            end
         end
         default: begin
            rs.result_block = rq.block_number;
            if ({1'b0, rq.block_number} >= lim) rs.status = STAT_RANGE;
            else rs.bit_value = occ_map[rq.block_number];
         end
      endcase
      rs.free_count = free_cnt;
      return rs;
   endfunction

   function automatic logic [15:0] pick_block();
      logic [16:0] lim;
      lim = tracked_blocks();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, lim + 3));
   endfunction

   function automatic void add_reg(csr_idx_type i, logic [16:0] v);
      stim_row_type row;
      row.kind = ROW_REG;
      row.idx = i;
      row.val = v;
      row.req = '0;
      row.typed = 0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_cmd(cmd_type c, logic [15:0] bn, bit typed, logic [15:0] blk,
                                   logic bv, logic [16:0] cnt, status_type st);
      stim_row_type row;
      row.kind = ROW_CMD;
      row.idx = CSR_TOTAL;
      row.val = '0;
      row.req.command = c;
      row.req.block_number = bn;
      row.typed = typed;
      row.want.result_block = blk;
      row.want.bit_value = bv;
      row.want.free_count = cnt;
      row.want.status = st;
      plan.push_back(row);
   endfunction

   task automatic issue(req_data_type rq, bit typed, rsp_data_type want, int idle_pct);
      rsp_data_type guess;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      guess = apply_command(rq);
      pending_rsp.push_back(typed ? want : guess);
      cmd_seen[rq.command]++;
      if (rq.command == CMD_INIT) held_blocks.delete();
      if (rq.command == CMD_ALLOC && guess.status == STAT_OK)
         held_blocks.push_back(guess.result_block);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type i, logic [16:0] v, bit last);
      csr_valid <= 1'b1;
      csr_index <= i;
      csr_data <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (last) csr_valid <= 1'b0;
      if (i == CSR_TOTAL) reg_total = v;
      else reg_reserved = v;
      reg_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("Result transfer with nothing pending: block %0d status %0d",
                   rsp_data.result_block, rsp_data.status);
            fails++;
         end else begin
            want_rsp = pending_rsp.pop_front();
            stat_seen[rsp_data.status]++;
            if (rsp_data.result_block !== want_rsp.result_block) begin
               $error("result_block: expected %0d, got %0d",
                      want_rsp.result_block, rsp_data.result_block);
               fails++;
            end
            if (rsp_data.bit_value !== want_rsp.bit_value) begin
               $error("bit_value: expected %0d, got %0d", want_rsp.bit_value, rsp_data.bit_value);
               fails++;
            end
            if (rsp_data.free_count !== want_rsp.free_count) begin
               $error("free_count: expected %0d, got %0d",
                      want_rsp.free_count, rsp_data.free_count);
               fails++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               fails++;
            end
         end
      end
   end

   initial begin
      int            idle_pct_by_phase[5];
      logic [16:0]   t;
      logic [16:0]   r;
      req_data_type  rq;
      int            pick;
      int            slot;
      bit            last;

      idle_pct_by_phase = '{0, 50, 0, 15, 15};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd0,     1'b0, 17'd0,     STAT_NOSPACE);
      add_cmd(CMD_READ,  16'hFFFF,  1, 16'hFFFF,  1'b0, 17'd0,     STAT_OK);
      add_cmd(CMD_FREE,  16'h1234,  1, 16'h1234,  1'b0, 17'd0,     STAT_OK);
      add_reg(CSR_TOTAL, 17'd40);
      add_reg(CSR_RESERVED, 17'd3);
      add_cmd(CMD_INIT,  16'hABCD,  1, 16'd0,     1'b0, 17'd37,    STAT_OK);
      add_cmd(CMD_ALLOC, 16'h5555,  1, 16'd3,     1'b0, 17'd36,    STAT_OK);
      add_cmd(CMD_READ,  16'd0,     1, 16'd0,     1'b1, 17'd36,    STAT_OK);
      add_cmd(CMD_READ,  16'd40,    1, 16'd40,    1'b0, 17'd36,    STAT_RANGE);
      add_cmd(CMD_FREE,  16'hFFFF,  1, 16'hFFFF,  1'b0, 17'd36,    STAT_RANGE);
      add_cmd(CMD_FREE,  16'd1,     1, 16'd1,     1'b0, 17'd37,    STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd1,     1'b0, 17'd36,    STAT_OK);
      add_cmd(CMD_FREE,  16'd39,    1, 16'd39,    1'b0, 17'd36,    STAT_OK);
      add_reg(CSR_TOTAL, 17'd0);
      add_cmd(CMD_READ,  16'd0,     1, 16'd0,     1'b0, 17'd36,    STAT_RANGE);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd0,     1'b0, 17'd36,    STAT_NOSPACE);
      add_reg(CSR_TOTAL, 17'd70000);
      add_reg(CSR_RESERVED, 17'h1FFFF);
      add_cmd(CMD_INIT,  16'd0,     1, 16'd0,     1'b0, 17'd0,     STAT_OK);
      add_cmd(CMD_READ,  16'hFFFF,  1, 16'hFFFF,  1'b1, 17'd0,     STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd0,     1'b0, 17'd0,     STAT_NOSPACE);
      add_cmd(CMD_FREE,  16'h8000,  1, 16'h8000,  1'b0, 17'd1,     STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'h8000,  1'b0, 17'd0,     STAT_OK);
      add_reg(CSR_TOTAL, 17'd65536);
      add_reg(CSR_RESERVED, 17'd0);
      add_cmd(CMD_INIT,  16'd0,     1, 16'd0,     1'b0, 17'd65536, STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     0, 16'd0,     1'b0, 17'd0,     STAT_OK);
      add_cmd(CMD_FREE,  16'd0,     0, 16'd0,     1'b0, 17'd0,     STAT_OK);
      add_reg(CSR_TOTAL, 17'd1);
      add_cmd(CMD_INIT,  16'd0,     1, 16'd0,     1'b0, 17'd1,     STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd0,     1'b0, 17'd0,     STAT_OK);
      add_cmd(CMD_ALLOC, 16'd0,     1, 16'd0,     1'b0, 17'd0,     STAT_NOSPACE);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            if (i == 0 || plan[i-1].kind == ROW_CMD) drain();
            last = (i + 1 >= plan.size()) ? 1'b1 : (plan[i+1].kind != ROW_REG);
            csr_write(plan[i].idx, plan[i].val, last);
         end else begin
            issue(plan[i].req, plan[i].typed, plan[i].want, 0);
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               t = 17'($urandom_range(1, 64));
               r = 17'($urandom_range(0, t + 2));
            end
            1: begin
               t = 17'($urandom_range(65, 300));
               r = 17'($urandom_range(0, 40));
            end
            2: begin
               t = 17'd65536;
               r = 17'($urandom_range(0, 65536));
            end
            3: begin
               t = 17'($urandom_range(65537, 131071));
               r = 17'($urandom_range(60000, 131071));
            end
            default: begin
               t = 17'($urandom_range(0, 128));
               r = 17'($urandom);
            end
         endcase
         drain();
         csr_write(CSR_TOTAL, t, 1'b0);
         csr_write(CSR_RESERVED, r, 1'b1);
         // The last phase keeps the old map and count so that later scans and range
         // checks run against registers that changed after the init.
         if (ph != 4) begin
            rq.command = CMD_INIT;
            rq.block_number = 16'($urandom);
            issue(rq, 0, '0, idle_pct_by_phase[ph]);
         end
         for (int n = 0; n < 54; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               rq.command = CMD_INIT;
               rq.block_number = 16'($urandom);
            end else if (pick < 45) begin
               rq.command = CMD_ALLOC;
               rq.block_number = 16'($urandom);
            end else if (pick < 75) begin
               rq.command = CMD_FREE;
               if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
                  slot = $urandom_range(0, held_blocks.size() - 1);
                  rq.block_number = held_blocks[slot];
                  held_blocks.delete(slot);
               end else begin
                  rq.block_number = pick_block();
               end
            end else begin
               rq.command = CMD_READ;
               rq.block_number = pick_block();
            end
            issue(rq, 0, '0, idle_pct_by_phase[ph]);
         end
      end

      drain();
      repeat (16) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         fails++;
      end

      $display("Commands: %0d init, %0d allocate, %0d free, %0d read; %0d register writes.",
               cmd_seen[CMD_INIT], cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE],
               cmd_seen[CMD_READ], reg_writes);
      $display("Results checked: %0d ok, %0d no space, %0d out of range.",
               stat_seen[STAT_OK], stat_seen[STAT_NOSPACE], stat_seen[STAT_RANGE]);
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dpath.sv
hw/rtl/block_bitmap_allocator_top.sv
sim/block_bitmap_allocator_top_tb.sv
